[rtl/core/datediff_pkg.sv]
`timescale 1ns / 1ps
// types, constants and the month table of the date difference core
// no dependencies

package datediff_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned ORD_W   = 23;
    localparam int unsigned DIST_W  = 22;
    localparam int unsigned PROD_W  = 28;
    localparam int unsigned QUOT_W  = 9;
    localparam int unsigned MOFF_W  = 9;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2**15
    localparam logic [PROD_W-1:0] RECIP_100   = 28'd5243;
    localparam int unsigned       RECIP_SHIFT = 19;

    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // first pipeline stage, one date
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [12:0]        cnt4;
        logic [PROD_W-1:0]  prod100;
        logic [PROD_W-1:0]  prod400;
        logic [PROD_W-1:0]  prod_year;
        logic [ORD_W-1:0]   year365;
    } s1_date_t;

    // second pipeline stage, one date
    typedef struct packed {
        logic [ORD_W-1:0]  part;
        logic [MOFF_W-1:0] moff;
    } s2_date_t;

    // days of the months before month m in a common year
    function automatic logic [MOFF_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/date_difference_days_core.sv]
`timescale 1ns / 1ps
// days between two proleptic gregorian dates, four stage pipeline
// depends on datediff_pkg

// Takes a pair of dates in one input word and returns the absolute number of days
// between them, one result word per input word. Each date becomes a day ordinal
// (365 per year, leap days before the year, days before the month, the day) and the
// two ordinals are subtracted; leap years follow the 4/100/400 rule with year 0 a
// leap year. Month 0 counts as January and months above 12 as December; results
// above 4194303 saturate. The pipeline has four register stages (constant
// multiplies, ordinal terms and leap test, ordinal sum, difference and output
// register), and a result passes through them in that order; a new word is taken
// every cycle while the output side keeps up. Each stage holds its word under
// back-pressure and bubbles are squeezed out.
module date_difference_days_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_year, first_month, first_day, second_year, second_month, second_day
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_distance, then zero fill
    output logic [23:0] m_tdata
);
    import datediff_pkg::*;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic                  rdy1, rdy2, rdy3, rdy4;
    s1_date_t              s1_reg [2];
    s1_date_t              s1_next [2];
    s2_date_t              s2_reg [2];
    s2_date_t              s2_next [2];
    logic [ORD_W-1:0]      ord_reg [2];
    logic [DIST_W-1:0]     dist_reg;
    logic [DIST_W-1:0]     dist_next;
    logic [ORD_W-1:0]      diff;

    // ready chain, a stage moves on when empty or when the next one moves
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // stage 1: unpack, clamp month, constant multiplies
    always_comb begin
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        logic [14:0]        y99;
        logic [14:0]        y399;
        for (int i = 0; i < 2; i++) begin
            y = s_tdata[i*23 +: YEAR_W];
            m = s_tdata[i*23 + YEAR_W +: MONTH_W];
            d = s_tdata[i*23 + YEAR_W + MONTH_W +: DAY_W];
            if (m == '0) begin
                m = MONTH_JAN;
            end else if (m > MONTH_DEC) begin
                m = MONTH_DEC;
            end
            y99  = 15'(y) + 15'd99;
            y399 = 15'(y) + 15'd399;
            s1_next[i].year      = y;
            s1_next[i].month     = m;
            s1_next[i].day       = d;
            s1_next[i].cnt4      = 13'((15'(y) + 15'd3) >> 2);
            s1_next[i].prod100   = PROD_W'(y99) * RECIP_100;
            s1_next[i].prod400   = PROD_W'(y399 >> 2) * RECIP_100;
            s1_next[i].prod_year = PROD_W'(y) * RECIP_100;
            s1_next[i].year365   = ORD_W'(y) * ORD_W'(365);
        end
    end

    // stage 2: year part of the ordinal, leap test, month offset
    always_comb begin
        logic [QUOT_W-1:0] q100;
        logic [QUOT_W-1:0] q400;
        logic [QUOT_W-1:0] qy;
        logic              leap;
        for (int i = 0; i < 2; i++) begin
            q100 = s1_reg[i].prod100[RECIP_SHIFT +: QUOT_W];
            q400 = s1_reg[i].prod400[RECIP_SHIFT +: QUOT_W];
            qy   = s1_reg[i].prod_year[RECIP_SHIFT +: QUOT_W];
            // divisible by 4, and not a century unless divisible by 400
            leap = (s1_reg[i].year[1:0] == 2'd0)
                && ((15'(s1_reg[i].year) != 15'(qy) * 15'd100) || (qy[1:0] == 2'd0));
            s2_next[i].part = s1_reg[i].year365 + ORD_W'(s1_reg[i].cnt4)
                            + ORD_W'(q400) - ORD_W'(q100);
            s2_next[i].moff = days_before(s1_reg[i].month)
                            + MOFF_W'(leap && (s1_reg[i].month > MONTH_FEB))
                            + MOFF_W'(s1_reg[i].day);
        end
    end

    // stage 4: absolute difference with saturation
    always_comb begin
        diff = (ord_reg[0] > ord_reg[1]) ? (ord_reg[0] - ord_reg[1])
                                         : (ord_reg[1] - ord_reg[0]);
        dist_next = diff[ORD_W-1] ? DIST_MAX : diff[DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg) begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg) begin
            for (int i = 0; i < 2; i++) begin
                ord_reg[i] <= s2_reg[i].part + ORD_W'(s2_reg[i].moff);
            end
        end
        if (rdy4 && v3_reg) begin
            dist_reg <= dist_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {2'b00, dist_reg};

    // input only blocked when every stage holds a word
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input blocked with an empty stage");

    // a word in stage 1 moving on reaches stage 2
    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("word lost between stage 1 and stage 2");

    // a result held under back-pressure keeps the last stage full
    a_output_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_tready) |=> (v4_reg && $stable(dist_reg)))
        else $error("held result changed");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for date_difference_days_core: date pair words in, day distance words out
// depends on datediff_pkg and date_difference_days_core

module testbench;
    import datediff_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned SETTLE_TICKS = 10;

    // s_tdata layout from bit 0 up: first_year, first_month, first_day,
    // second_year, second_month, second_day, zero fill
    typedef struct packed {
        logic [1:0]         fill;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
    } date_pair_t;

    typedef struct {
        date_pair_t        pair;
        logic [DIST_W-1:0] distance;
    } pending_distance_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    bit                idle_on = 1'b1;
    int unsigned       error_count = 0;
    int unsigned       stalled_cycles = 0;
    pending_distance_t pending_distances[$];
    pending_distance_t oldest;

    date_difference_days_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // ---------------------------------------------------------------- calendar arithmetic

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input bit leap);
        case (m)
            2:           return 28 + leap;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // day count from a fixed epoch; out-of-range months are pinned to jan / dec
    function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned n;
        int unsigned mm;
        int unsigned k;
        bit          leap;
        mm   = (m < MONTH_JAN) ? MONTH_JAN : ((m > MONTH_DEC) ? MONTH_DEC : m);
        leap = is_leap_year(y);
        n    = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (k = 1; k < mm; k++)
            n += month_length(k, leap);
        return n + d;
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(input date_pair_t p);
        int unsigned a;
        int unsigned b;
        int unsigned gap;
        a   = day_number(p.first_year, p.first_month, p.first_day);
        b   = day_number(p.second_year, p.second_month, p.second_day);
        gap = (a > b) ? a - b : b - a;
        if (gap > DIST_MAX)
            return DIST_MAX;
        return gap[DIST_W-1:0];
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic date_pair_t make_pair(input int unsigned y1, input int unsigned m1,
                                             input int unsigned d1, input int unsigned y2,
                                             input int unsigned m2, input int unsigned d2);
        date_pair_t p;
        p              = '0;
        p.first_year   = y1[YEAR_W-1:0];
        p.first_month  = m1[MONTH_W-1:0];
        p.first_day    = d1[DAY_W-1:0];
        p.second_year  = y2[YEAR_W-1:0];
        p.second_month = m2[MONTH_W-1:0];
        p.second_day   = d2[DAY_W-1:0];
        return p;
    endfunction

    function automatic void pick_valid_date(output int unsigned y, output int unsigned m,
                                            output int unsigned d);
        y = $urandom_range(0, 9999);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_length(m, is_leap_year(y)));
    endfunction

    function automatic date_pair_t random_pair();
        int unsigned y1, m1, d1, y2, m2, d2;
        pick_valid_date(y1, m1, d1);
        y2 = y1;
        m2 = m1;
        d2 = d1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                pick_valid_date(y2, m2, d2);
            end
            5, 6: begin
                // second date in the same or the next year
                if (y1 < 9999)
                    y2 = y1 + $urandom_range(0, 1);
                m2 = $urandom_range(1, 12);
                d2 = $urandom_range(1, month_length(m2, is_leap_year(y2)));
            end
            7: ;  // identical dates
            default: begin
                // any field value at all, years past 9999 and bad months included
                y1 = $urandom_range(0, 16383);
                m1 = $urandom_range(0, 15);
                d1 = $urandom_range(0, 31);
                y2 = $urandom_range(0, 16383);
                m2 = $urandom_range(0, 15);
                d2 = $urandom_range(0, 31);
            end
        endcase
        return make_pair(y1, m1, d1, y2, m2, d2);
    endfunction

    task automatic send_pair(input date_pair_t p);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do
            @(posedge aclk);
        while (!s_tready);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_calendar_cases();
        send_pair(make_pair(2024, 5, 17, 2024, 5, 17));
        send_pair(make_pair(2000, 1, 1, 2000, 3, 1));      // leap by the 400 rule
        send_pair(make_pair(1900, 2, 28, 1900, 3, 1));     // century, not leap
        send_pair(make_pair(2004, 2, 29, 2004, 3, 1));
        send_pair(make_pair(0, 1, 1, 0, 12, 31));          // year zero is leap
        send_pair(make_pair(0, 1, 1, 1, 1, 1));
        send_pair(make_pair(0, 1, 1, 9999, 12, 31));       // widest valid span
        send_pair(make_pair(9999, 12, 31, 0, 1, 1));
        send_pair(make_pair(2100, 12, 31, 2101, 1, 1));
        send_pair(make_pair(1999, 12, 31, 2000, 1, 1));
        send_pair(make_pair(2023, 1, 31, 2023, 2, 1));
    endtask

    task automatic test_malformed_dates();
        send_pair(make_pair(2001, 0, 15, 2001, 1, 15));    // month zero as january
        send_pair(make_pair(2001, 13, 1, 2001, 12, 1));    // month past twelve as december
        send_pair(make_pair(2001, 3, 0, 2001, 2, 28));     // day zero
        send_pair(make_pair(2000, 2, 31, 2000, 3, 2));     // day past month end
        send_pair(make_pair(2001, 4, 31, 2001, 5, 1));
        send_pair(make_pair(2001, 2, 31, 2001, 3, 1));     // wrong order once ordered
        send_pair(make_pair(10000, 1, 1, 9999, 12, 31));   // year past 9999
        send_pair(make_pair(12000, 6, 6, 9000, 6, 6));
        send_pair(make_pair(16383, 15, 31, 0, 1, 1));      // saturates
        send_pair(make_pair(0, 0, 0, 16383, 15, 31));
    endtask

    task automatic test_random_pairs();
        int unsigned chunk;
        int unsigned n;
        for (chunk = 0; chunk < 16; chunk++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < 100; n++)
                send_pair(random_pair());
        end
        idle_on = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        int unsigned round;
        int unsigned n;
        for (round = 0; round < 2; round++) begin
            for (n = 0; n < 50; n++)
                send_pair(random_pair());
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        int unsigned n;
        idle_on = 1'b0;
        for (n = 0; n < 300; n++)
            send_pair(random_pair());
    endtask

    // ---------------------------------------------------------------- checking

    // compare first, then record, so a result never meets its own word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_distances.size() == 0) begin
                report_mismatch($sformatf("result word %0d with nothing pending",
                                          m_tdata[DIST_W-1:0]));
            end else begin
                oldest = pending_distances.pop_front();
                if (m_tdata[DIST_W-1:0] !== oldest.distance)
                    report_mismatch($sformatf(
                        "%0d-%0d-%0d to %0d-%0d-%0d: day_distance %0d, want %0d",
                        oldest.pair.first_year, oldest.pair.first_month,
                        oldest.pair.first_day, oldest.pair.second_year,
                        oldest.pair.second_month, oldest.pair.second_day,
                        m_tdata[DIST_W-1:0], oldest.distance));
            end
        end
        if (aresetn && s_tvalid && s_tready)
            pending_distances.push_back('{date_pair_t'(s_tdata),
                                          predict_distance(date_pair_t'(s_tdata))});
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles == STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (idle_on && $urandom_range(0, 1) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_calendar_cases();
        test_malformed_dates();
        test_random_pairs();
        test_pause_until_drained();
        test_back_to_back();

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
